>>> rtl/plt_pkg.sv
package plt_pkg;

  localparam int LIMIT_W     = 9;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int MAX_RESULTS = 64;
  localparam int BIT_CNT_W   = 4;

  typedef struct packed {
    logic               start;
    logic [LIMIT_W-1:0] dividend;
    logic [LIMIT_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_rsp_t;

endpackage

>>> rtl/plt_if.sv
interface plt_in_if;
  logic                        valid;
  logic                        ready;
  logic [plt_pkg::LIMIT_W-1:0] limit;

  modport source (output valid, output limit, input ready);
  modport sink (input valid, input limit, output ready);
endinterface

interface plt_out_if;
  logic                        valid;
  logic                        ready;
  logic [plt_pkg::LIMIT_W-1:0] prime_value;
  logic [plt_pkg::IDX_W-1:0]   prime_index;
  logic [plt_pkg::CNT_W-1:0]   prime_count;
  logic                        found;
  logic                        last;

  modport source (output valid, output prime_value, output prime_index,
                  output prime_count, output found, output last, input ready);
  modport sink (input valid, input prime_value, input prime_index,
                input prime_count, input found, input last, output ready);
endinterface

>>> rtl/plt_rem.sv
module plt_rem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  plt_pkg::rem_req_t req_i,
  output plt_pkg::rem_rsp_t rsp_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [plt_pkg::BIT_CNT_W-1:0]     cnt_q, cnt_d;
  logic [plt_pkg::LIMIT_W-1:0]       dvd_q, dvd_d;
  logic [plt_pkg::LIMIT_W-1:0]       dsr_q, dsr_d;
  logic [plt_pkg::LIMIT_W-1:0]       rem_q, rem_d;
  logic [plt_pkg::LIMIT_W:0]         trial;
  logic [plt_pkg::LIMIT_W-1:0]       step;

  always_comb begin
    trial = {rem_q, dvd_q[plt_pkg::LIMIT_W-1]};
    if (trial >= {1'b0, dsr_q}) begin
      step = plt_pkg::LIMIT_W'(trial - {1'b0, dsr_q});
    end else begin
      step = trial[plt_pkg::LIMIT_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = plt_pkg::BIT_CNT_W'(plt_pkg::LIMIT_W);
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = step;
      dvd_d = {dvd_q[plt_pkg::LIMIT_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == plt_pkg::BIT_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.zero = (rem_q == '0);

endmodule

>>> rtl/plt_list.sv
module plt_list (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [plt_pkg::IDX_W-1:0]   waddr_i,
  input  logic [plt_pkg::LIMIT_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [plt_pkg::IDX_W-1:0]   raddr_i,
  output logic [plt_pkg::LIMIT_W-1:0] rdata_o
);

  logic [plt_pkg::LIMIT_W-1:0] mem_q [plt_pkg::MAX_RESULTS];
  logic [plt_pkg::LIMIT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/prime_list_trial_division_core.sv
// Channel  Direction  Payload                                              Handshake
// in_i     input      limit                                                valid / ready
// out_o    output     prime_value, prime_index, prime_count, found, last   valid / ready
//
// One item is taken at a time; in_i.ready is high only while the block is idle.
// Each trial divisor runs through the bit-serial remainder unit, one quotient bit
// per cycle; a prime c costs c - 2 trials, and a composite stops at its smallest
// factor. The primes are kept in a 64-entry list and then sent out one by one:
// each is read from the list, loaded into the output registers and held on out_o
// until taken. Reset returns the block to idle with no item pending.
module prime_list_trial_division_core #(
  parameter int MAX_LIMIT = 312
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  plt_in_if.sink           in_i,
  plt_out_if.source        out_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CAND = 3'd1;
  localparam logic [2:0] ST_TEST = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_LOAD = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  localparam logic [plt_pkg::LIMIT_W-1:0] LimitMax = plt_pkg::LIMIT_W'(MAX_LIMIT);

  logic [2:0]                   state_q, state_d;
  logic [plt_pkg::LIMIT_W-1:0]  lim_q, lim_d;
  logic [plt_pkg::LIMIT_W-1:0]  cand_q, cand_d;
  logic [plt_pkg::LIMIT_W-1:0]  div_q, div_d;
  logic [plt_pkg::CNT_W-1:0]    n_q, n_d;
  logic [plt_pkg::IDX_W-1:0]    k_q, k_d;
  logic [plt_pkg::LIMIT_W-1:0]  val_q, val_d;
  logic [plt_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [plt_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                         found_q, found_d;
  logic                         last_q, last_d;

  plt_pkg::rem_req_t            rem_req;
  plt_pkg::rem_rsp_t            rem_rsp;
  logic                         list_we;
  logic                         list_re;
  logic [plt_pkg::LIMIT_W-1:0]  list_rdata;

  plt_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  plt_list u_list (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (n_q[plt_pkg::IDX_W-1:0]),
    .wdata_i (cand_q),
    .re_i    (list_re),
    .raddr_i (k_q),
    .rdata_o (list_rdata)
  );

  always_comb begin
    state_d          = state_q;
    lim_d            = lim_q;
    cand_d           = cand_q;
    div_d            = div_q;
    n_d              = n_q;
    k_d              = k_q;
    val_d            = val_q;
    idx_d            = idx_q;
    cnt_d            = cnt_q;
    found_d          = found_q;
    last_d           = last_q;
    rem_req.start    = 1'b0;
    rem_req.dividend = cand_q;
    rem_req.divisor  = div_q;
    list_we          = 1'b0;
    list_re          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          lim_d   = (in_i.limit > LimitMax) ? LimitMax : in_i.limit;
          cand_d  = plt_pkg::LIMIT_W'(2);
          n_d     = '0;
          state_d = ST_CAND;
        end
      end
      ST_CAND: begin
        if (cand_q < lim_q && n_q != plt_pkg::CNT_W'(plt_pkg::MAX_RESULTS)) begin
          div_d   = plt_pkg::LIMIT_W'(2);
          state_d = ST_TEST;
        end else if (n_q == '0) begin
          val_d   = '0;
          idx_d   = '0;
          cnt_d   = '0;
          found_d = 1'b0;
          last_d  = 1'b1;
          state_d = ST_OUT;
        end else begin
          k_d     = '0;
          state_d = ST_RD;
        end
      end
      ST_TEST: begin
        if (div_q == cand_q) begin
          list_we = 1'b1;
          n_d     = n_q + 1'b1;
          cand_d  = cand_q + 1'b1;
          state_d = ST_CAND;
        end else begin
          rem_req.start = 1'b1;
          state_d       = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (rem_rsp.done) begin
          if (rem_rsp.zero) begin
            cand_d  = cand_q + 1'b1;
            state_d = ST_CAND;
          end else begin
            div_d   = div_q + 1'b1;
            state_d = ST_TEST;
          end
        end
      end
      ST_RD: begin
        list_re = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        val_d   = list_rdata;
        idx_d   = k_q;
        cnt_d   = n_q;
        found_d = 1'b1;
        last_d  = (plt_pkg::CNT_W'(k_q) + 1'b1 == n_q);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_o.ready) begin
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q   <= lim_d;
    cand_q  <= cand_d;
    div_q   <= div_d;
    k_q     <= k_d;
    val_q   <= val_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    found_q <= found_d;
    last_q  <= last_d;
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = (state_q == ST_OUT);
  assign out_o.prime_value = val_q;
  assign out_o.prime_index = idx_q;
  assign out_o.prime_count = cnt_q;
  assign out_o.found       = found_q;
  assign out_o.last        = last_q;

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input taken while a result is pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= plt_pkg::CNT_W'(plt_pkg::MAX_RESULTS))
    else $error("prime count overflow");

  a_load_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> $past(state_q == ST_RD))
    else $error("list data used without a read");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.found) |-> (out_o.last && out_o.prime_count == '0))
    else $error("empty result not marked last");

  a_prime_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.found) |-> (out_o.prime_value >= plt_pkg::LIMIT_W'(2)
      && plt_pkg::CNT_W'(out_o.prime_index) < out_o.prime_count))
    else $error("result fields out of range");
`endif

endmodule

>>> sim/prime_list_checker.sv
`timescale 1ns / 100ps

module prime_list_checker #(
  parameter int MAX_LIMIT = 312
) (
  input  logic clk_i,
  input  logic rst_ni,
  plt_in_if    in_i,
  plt_out_if   out_i,
  output int   fail_count_o,
  output int   outstanding_o
);

  typedef struct packed {
    logic [plt_pkg::LIMIT_W-1:0] value;
    logic [plt_pkg::IDX_W-1:0]   index;
    logic [plt_pkg::CNT_W-1:0]   count;
    logic                        found;
    logic                        last;
  } prime_result_t;

  prime_result_t expected_primes[$];
  int            fails = 0;

  function automatic bit is_prime(int cand);
    if (cand < 2) return 1'b0;
    for (int d = 2; d < cand; d++) begin
      if (cand % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Every prime below the saturated limit, up to MAX_RESULTS of them, in ascending order, or one empty result.
  function automatic void predict_primes(logic [plt_pkg::LIMIT_W-1:0] limit);
    int            lim;
    int            primes[$];
    prime_result_t res;
    lim = (limit > MAX_LIMIT) ? MAX_LIMIT : int'(limit);
    for (int cand = 2; cand < lim && primes.size() < plt_pkg::MAX_RESULTS; cand++) begin
      if (is_prime(cand)) primes.push_back(cand);
    end
    if (primes.size() == 0) begin
      res      = '0;
      res.last = 1'b1;
      expected_primes.push_back(res);
    end else begin
      for (int k = 0; k < primes.size(); k++) begin
        res.value = plt_pkg::LIMIT_W'(primes[k]);
        res.index = plt_pkg::IDX_W'(k);
        res.count = plt_pkg::CNT_W'(primes.size());
        res.found = 1'b1;
        res.last  = (k == primes.size() - 1);
        expected_primes.push_back(res);
      end
    end
  endfunction

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    prime_result_t want;
    if (rst_ni) begin
      if (in_i.valid && in_i.ready) begin
        predict_primes(in_i.limit);
      end
      if (out_i.valid && out_i.ready) begin
        if (expected_primes.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual value %0d index %0d",
                   $time, out_i.prime_value, out_i.prime_index);
          fails++;
        end else begin
          want = expected_primes.pop_front();
          check_field("prime_value", want.value, out_i.prime_value);
          check_field("prime_index", want.index, out_i.prime_index);
          check_field("prime_count", want.count, out_i.prime_count);
          check_field("found", want.found, out_i.found);
          check_field("last", want.last, out_i.last);
        end
      end
    end
    fail_count_o  <= fails;
    outstanding_o <= expected_primes.size();
  end

endmodule

>>> sim/tb_prime_list_trial_division_core.sv
`timescale 1ns / 100ps

module tb_prime_list_trial_division_core;

  localparam int MAX_LIMIT   = 312;
  localparam int HOLD_CYCLES = 20000;
  localparam int DRAIN       = 100;
  localparam int CYCLE_LIMIT = 40000000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_go   = 1'b0;
  int hold_cnt  = 0;
  int cycle_cnt = 0;
  int fail_count;
  int outstanding;

  int directed_limits[16] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 11, 12, 13, 100, 311, 312, 313};

  plt_in_if  in_if ();
  plt_out_if out_if ();

  prime_list_trial_division_core #(
    .MAX_LIMIT(MAX_LIMIT)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  prime_list_checker #(
    .MAX_LIMIT(MAX_LIMIT)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Once requested, the sink holds off for a long stretch so the block backs up.
  always @(posedge clk) begin
    if (hold_go && hold_cnt < HOLD_CYCLES) begin
      hold_cnt     <= hold_cnt + 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_limit(logic [plt_pkg::LIMIT_W-1:0] lim);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.limit <= lim;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Most limits stay small to keep the trial division short.
  function automatic logic [plt_pkg::LIMIT_W-1:0] pick_limit();
    if ($urandom_range(0, 49) == 0) return plt_pkg::LIMIT_W'($urandom_range(0, 511));
    return plt_pkg::LIMIT_W'($urandom_range(0, 63));
  endfunction

  initial begin
    in_if.valid   = 1'b0;
    in_if.limit   = '0;
    send_idle_pct = 10;
    recv_idle_pct = 76;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_limits[i]) send_limit(plt_pkg::LIMIT_W'(directed_limits[i]));
    send_limit(plt_pkg::LIMIT_W'(511));
    for (int i = 0; i < 34; i++) send_limit(pick_limit());

    send_idle_pct = 76;
    recv_idle_pct = 10;
    for (int i = 0; i < 33; i++) send_limit(pick_limit());

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go       = 1'b1;
    for (int i = 0; i < 33; i++) send_limit(pick_limit());
    in_if.valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> prime_list_trial_division_core.f
rtl/plt_pkg.sv
rtl/plt_if.sv
rtl/plt_rem.sv
rtl/plt_list.sv
rtl/prime_list_trial_division_core.sv
sim/prime_list_checker.sv
sim/tb_prime_list_trial_division_core.sv
